FILE: hw/rtl/sia_pkg.sv
// Shared types and opcodes of the stack integer ALU.
`default_nettype none
package sia_pkg;

  // Opcodes carried in the command field
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_NEG = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_ABS = 4'd8,
    OP_POW = 4'd9
  } op_t;

  // Operand pair for the shared multiplier; also names where the product goes
  typedef enum logic [1:0] {
    MS_XY  = 2'd0,  // top * next   -> result
    MS_ACC = 2'd1,  // acc * base   -> acc
    MS_SQ  = 2'd2   // base * base  -> base, exponent shifts right
  } mul_sel_t;

  // Multiplier partial-product phases
  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_HL = 2'd1;
  localparam logic [1:0] PH_LH = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic     load;       // capture an input word
    logic     simple;     // write the simple-operation result
    logic     div_step;   // one restoring divide step
    logic     div_fin;    // apply signs to quotient or remainder
    logic     mul_run;    // advance the multiplier one phase
    mul_sel_t mul_sel;
    logic     take_acc;   // power result is the accumulator
    logic     out_load;   // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [3:0] op;
    logic       div_zero;
    logic       exp_nonpos;
    logic       exp_zero;
    logic       exp_lsb;
    logic       div_last;
    logic       mul_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sia_if.sv
// Valid/ready channel interfaces for the ALU input and result words.
`default_nettype none
interface sia_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [63:0] first_operand;
  logic signed [63:0] second_operand;

  modport source (output valid, output command, output first_operand,
                  output second_operand, input ready);
  modport sink   (input valid, input command, input first_operand,
                  input second_operand, output ready);
endinterface

interface sia_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sia_ctrl.sv
// Sequencing state machine of the stack integer ALU.
`default_nettype none
module sia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sia_pkg::sts_t sts,
  output sia_pkg::cmd_t      cmd
);
  import sia_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_DFIN  = 9'b000010000,
    S_PSTEP = 9'b000100000,
    S_PACC  = 9'b001000000,
    S_PSQ   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MS_XY;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        // closed while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_MUL: state_nxt = S_MUL;
          OP_DIV, OP_MOD: begin
            if (sts.div_zero) begin
              cmd.simple = 1'b1;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_DIV;
            end
          end
          OP_POW: begin
            if (sts.exp_nonpos) begin
              cmd.simple = 1'b1;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_PSTEP;
            end
          end
          default: begin
            cmd.simple = 1'b1;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_run = 1'b1;
        if (sts.mul_done) state_nxt = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_PSTEP: begin
        if (sts.exp_zero) begin
          cmd.take_acc = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.exp_lsb) begin
          state_nxt = S_PACC;
        end else begin
          state_nxt = S_PSQ;
        end
      end
      S_PACC: begin
        cmd.mul_run = 1'b1;
        cmd.mul_sel = MS_ACC;
        if (sts.mul_done) state_nxt = S_PSQ;
      end
      S_PSQ: begin
        cmd.mul_run = 1'b1;
        cmd.mul_sel = MS_SQ;
        if (sts.mul_done) state_nxt = S_PSTEP;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sia_dp.sv
// Datapath: operand registers, divider, shared multiplier, output register.
`default_nettype none
module sia_dp #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sia_pkg::cmd_t      cmd,
  output sia_pkg::sts_t           sts,
  input  wire logic [3:0]         in_command,
  input  wire logic signed [63:0] in_first_operand,
  input  wire logic signed [63:0] in_second_operand,
  output logic                    out_valid,
  output logic signed [63:0]      out_result,
  input  wire logic               out_ready
);
  import sia_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]    op_r;
  logic [W-1:0]  x_r, y_r, rslt_r;
  logic [W-1:0]  acc_r, base_r, exp_r;
  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    mph_r;
  logic [W-1:0]  mp_r, mp_nxt;
  logic          out_valid_r;
  logic [W-1:0]  out_res_r;

  logic [W-1:0] in_x, in_y;
  assign in_x = in_first_operand[W-1:0];
  assign in_y = in_second_operand[W-1:0];

  // Combinational operations; div/mod give 0 on zero divisor, pow gives 1
  logic [W-1:0] simple_res;
  always_comb begin
    case (op_r)
      OP_ADD:  simple_res = x_r + y_r;
      OP_SUB:  simple_res = x_r - y_r;
      OP_NEG:  simple_res = ~x_r + 1'b1;
      OP_INC:  simple_res = x_r + 1'b1;
      OP_DEC:  simple_res = x_r - 1'b1;
      OP_ABS:  simple_res = mag(x_r);
      OP_POW:  simple_res = W'(1);
      default: simple_res = '0;
    endcase
  end

  // Restoring divide step on magnitudes
  logic [W:0]   rem_sh, diff;
  logic         fits;
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign fits   = !diff[W];

  // Sign fix of the divide result
  logic [W-1:0] div_res;
  always_comb begin
    if (op_r == OP_MOD) begin
      div_res = x_r[W-1] ? (~rem_r + 1'b1) : rem_r;
    end else begin
      div_res = (x_r[W-1] ^ y_r[W-1]) ? (~quo_r + 1'b1) : quo_r;
    end
  end

  // Shared multiplier: one HxH partial product per phase, low W bits kept
  logic [W-1:0]   ma, mb;
  logic [H-1:0]   ma_lo, ma_hi, mb_lo, mb_hi, fa, fb;
  logic [2*H-1:0] pp;
  logic [3*H-1:0] pp_sh;
  logic [W-1:0]   pp_term;

  always_comb begin
    case (cmd.mul_sel)
      MS_ACC: begin
        ma = acc_r;
        mb = base_r;
      end
      MS_SQ: begin
        ma = base_r;
        mb = base_r;
      end
      default: begin
        ma = x_r;
        mb = y_r;
      end
    endcase
  end

  assign ma_lo = ma[H-1:0];
  assign mb_lo = mb[H-1:0];
  assign ma_hi = H'(ma[W-1:H]);
  assign mb_hi = H'(mb[W-1:H]);

  always_comb begin
    case (mph_r)
      PH_LL: begin
        fa = ma_lo;
        fb = mb_lo;
      end
      PH_HL: begin
        fa = ma_hi;
        fb = mb_lo;
      end
      default: begin
        fa = ma_lo;
        fb = mb_hi;
      end
    endcase
  end

  assign pp      = fa * fb;
  assign pp_sh   = {pp, {H{1'b0}}};
  assign pp_term = (mph_r == PH_LL) ? pp[W-1:0] : pp_sh[W-1:0];
  assign mp_nxt  = ((mph_r == PH_LL) ? '0 : mp_r) + pp_term;

  logic mul_done;
  assign mul_done = cmd.mul_run && (mph_r == PH_LH);

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_command;
      x_r    <= in_x;
      y_r    <= in_y;
      acc_r  <= W'(1);
      base_r <= in_y;
      exp_r  <= in_x;
      rem_r  <= '0;
      quo_r  <= mag(in_x);
      dvs_r  <= mag(in_y);
      cnt_r  <= '0;
      mph_r  <= PH_LL;
    end else begin
      if (cmd.div_step) begin
        rem_r <= fits ? diff[W-1:0] : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.mul_run) begin
        mp_r  <= mp_nxt;
        mph_r <= mul_done ? PH_LL : (mph_r + 1'b1);
      end
      if (mul_done && cmd.mul_sel == MS_ACC) acc_r <= mp_nxt;
      if (mul_done && cmd.mul_sel == MS_SQ) begin
        base_r <= mp_nxt;
        exp_r  <= {1'b0, exp_r[W-1:1]};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.simple) begin
      rslt_r <= simple_res;
    end else if (cmd.div_fin) begin
      rslt_r <= div_res;
    end else if (cmd.take_acc) begin
      rslt_r <= acc_r;
    end else if (mul_done && cmd.mul_sel == MS_XY) begin
      rslt_r <= mp_nxt;
    end
  end

  // Output register: holds a finished word while the next one is worked on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_res_r <= rslt_r;
  end

  assign out_valid  = out_valid_r;
  assign out_result = 64'($signed(out_res_r));

  // Status back to the controller
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.div_zero   = (y_r == '0);
    sts.exp_nonpos = x_r[W-1] || (x_r == '0);
    sts.exp_zero   = (exp_r == '0);
    sts.exp_lsb    = exp_r[0];
    sts.div_last   = (cnt_r == CNT_LAST);
    sts.mul_done   = mul_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/stack_integer_alu.sv
// Top level of the stack integer ALU: controller, datapath and channels.
// An accepted word passes DISP and ends in DONE, which waits for a free output register:
//   add/sub/neg/inc/dec/abs, unused opcodes, zero-divisor div/mod and non-positive pow go
//   there directly; mul runs the multiplier; div/mod do one step per bit, then DFIN.
// Pow: per exponent bit up to its top set bit a squaring, after an accumulate if the bit
//   is set, both on the three-phase shared multiplier; one word at a time.
// Reset (synchronous, rst_n low) idles the controller and empties the output register.
`default_nettype none
module stack_integer_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sia_in_if.sink     in_if,
  sia_out_if.source  out_if
);
  import sia_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sia_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_if.command),
    .in_first_operand  (in_if.first_operand),
    .in_second_operand (in_if.second_operand),
    .out_valid         (out_if.valid),
    .out_result        (out_if.result),
    .out_ready         (out_if.ready)
  );

  // Accepting a word closes the input until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken while a word is in flight");

  // A result never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_if.valid || out_if.ready))
    else $error("output register overwritten");

  // A multiply, once started, runs through its phases without a break
  a_mul_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_run && !sts.mul_done |=> cmd.mul_run)
    else $error("multiply sequence interrupted");

endmodule
`default_nettype wire
